// ===== hdl/wrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// wrhp_pkg
// Types and constants shared by the WAV header parser modules.
// ----------------------------------------------------------------------------
package wrhp_pkg;

  localparam logic [31:0] ID_RIFF = 32'h46464952;
  localparam logic [31:0] ID_WAVE = 32'h45564157;
  localparam logic [31:0] ID_FMT  = 32'h20746d66;
  localparam logic [31:0] ID_LIST = 32'h5453494c;
  localparam logic [31:0] ID_INFO = 32'h4f464e49;
  localparam logic [31:0] ID_IART = 32'h54524149;
  localparam logic [31:0] ID_INAM = 32'h4d414e49;
  localparam logic [31:0] ID_DATA = 32'h61746164;

  localparam logic [17:0] RATE_RESET = 18'd48000;
  localparam logic [3:0]  CHAN_RESET = 4'd2;
  localparam logic [15:0] FMT_SIZE   = 16'd16;
  localparam logic [15:0] FMT_BITS   = 16'd16;

  localparam logic [0:0] CFG_RATE = 1'b0;
  localparam logic [0:0] CFG_CHAN = 1'b1;

  localparam logic [2:0] KIND_ARTIST = 3'd0;
  localparam logic [2:0] KIND_TITLE  = 3'd1;
  localparam logic [2:0] KIND_TEXTEND = 3'd2;
  localparam logic [2:0] KIND_HEADER = 3'd3;
  localparam logic [2:0] KIND_PCM    = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;

  localparam logic [2:0] ERR_NO_RIFF = 3'd0;
  localparam logic [2:0] ERR_NO_WAVE = 3'd1;
  localparam logic [2:0] ERR_BAD_FMT = 3'd2;
  localparam logic [2:0] ERR_UNSUP   = 3'd3;
  localparam logic [2:0] ERR_ZERO    = 3'd4;
  localparam logic [2:0] ERR_EARLY   = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] value;
    logic [2:0]  error_code;
    logic        channel;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } slot_t;

  // Up to two results caused by one input item.
  typedef struct packed {
    slot_t a;
    slot_t b;
  } pair_t;

endpackage

// ===== hdl/wrhp_front.sv =====
// ----------------------------------------------------------------------------
// wrhp_front
// Byte parser: tracks the RIFF structure and classifies each byte into
// zero, one or two results for the back end.
// ----------------------------------------------------------------------------
module wrhp_front #(
  parameter int MAX_TEXT = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             func,
  input  logic [7:0]       data_byte,
  input  logic [17:0]      exp_rate,
  input  logic [3:0]       exp_chan,
  output wrhp_pkg::pair_t  pair
);
  import wrhp_pkg::*;

  typedef enum logic [11:0] {
    S_RIFF_ID   = 12'b000000000001,
    S_RIFF_SIZE = 12'b000000000010,
    S_WAVE_ID   = 12'b000000000100,
    S_FMT_HDR   = 12'b000000001000,
    S_FMT_BODY  = 12'b000000010000,
    S_CHUNK_HDR = 12'b000000100000,
    S_LIST_TYPE = 12'b000001000000,
    S_SKIP      = 12'b000010000000,
    S_TEXT      = 12'b000100000000,
    S_DATA      = 12'b001000000000,
    S_DONE      = 12'b010000000000,
    S_FAILED    = 12'b100000000000
  } state_t;

  localparam logic [7:0] TEXT_LIM = 8'(MAX_TEXT - 1);

  state_t      state_r, state_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] id_r, id_nxt;
  logic [31:0] left_r, left_nxt;
  logic        pad_r, pad_nxt;
  logic [7:0]  tcnt_r, tcnt_nxt;
  logic        ttgt_r, ttgt_nxt;
  logic        tstop_r, tstop_nxt;
  logic [30:0] samp_r, samp_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        chtg_r, chtg_nxt;
  logic        fbad_r, fbad_nxt;
  logic        info_r, info_nxt;
  pair_t       pair_nxt;

  logic [31:0] w;
  logic [15:0] half;
  logic [31:0] left_dec;
  logic [30:0] samp_dec;
  logic [7:0]  tcnt_inc;

  function automatic result_t mk(input logic [2:0] k, input logic [31:0] v,
                                 input logic [2:0] c, input logic ch,
                                 input logic l);
    result_t r;
    r.kind = k;
    r.value = v;
    r.error_code = c;
    r.channel = ch;
    r.last = l;
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r;
    word_nxt = word_r;
    id_nxt = id_r;
    left_nxt = left_r;
    pad_nxt = pad_r;
    tcnt_nxt = tcnt_r;
    ttgt_nxt = ttgt_r;
    tstop_nxt = tstop_r;
    samp_nxt = samp_r;
    low_nxt = low_r;
    chtg_nxt = chtg_r;
    fbad_nxt = fbad_r;
    info_nxt = info_r;
    pair_nxt = '0;
    w = {data_byte, word_r[31:8]};
    half = w[31:16];
    left_dec = left_r - 32'd1;
    samp_dec = samp_r - 31'd1;
    tcnt_inc = tcnt_r + 8'd1;
    if (step) begin
      if (func) begin
        if (state_r != S_DONE && state_r != S_FAILED) begin
          pair_nxt.a.valid = 1'b1;
          pair_nxt.a.res = mk(KIND_ERROR, '0, ERR_EARLY, 1'b0, 1'b0);
        end
        state_nxt = S_RIFF_ID;
        pos_nxt = '0;
        word_nxt = '0;
        id_nxt = '0;
        left_nxt = '0;
        pad_nxt = 1'b0;
        tcnt_nxt = '0;
        ttgt_nxt = 1'b0;
        tstop_nxt = 1'b0;
        samp_nxt = '0;
        low_nxt = '0;
        chtg_nxt = 1'b0;
        fbad_nxt = 1'b0;
        info_nxt = 1'b0;
      end else begin
        word_nxt = w;
        unique case (state_r)
          S_RIFF_ID, S_RIFF_SIZE, S_WAVE_ID: begin
            if (pos_r < 5'd3) begin
              pos_nxt = pos_r + 5'd1;
            end else begin
              pos_nxt = '0;
              if (state_r == S_RIFF_ID && w != ID_RIFF) begin
                state_nxt = S_FAILED;
                pair_nxt.a.valid = 1'b1;
                pair_nxt.a.res = mk(KIND_ERROR, '0, ERR_NO_RIFF, 1'b0, 1'b0);
              end else if (state_r == S_WAVE_ID && w != ID_WAVE) begin
                state_nxt = S_FAILED;
                pair_nxt.a.valid = 1'b1;
                pair_nxt.a.res = mk(KIND_ERROR, '0, ERR_NO_WAVE, 1'b0, 1'b0);
              end else if (state_r == S_WAVE_ID) begin
                state_nxt = S_FMT_HDR;
              end else if (state_r == S_RIFF_ID) begin
                state_nxt = S_RIFF_SIZE;
              end else begin
                state_nxt = S_WAVE_ID;
              end
            end
          end
          S_FMT_HDR: begin
            if (pos_r == 5'd3) begin
              id_nxt = w;
            end
            if (pos_r < 5'd7) begin
              pos_nxt = pos_r + 5'd1;
            end else begin
              pos_nxt = '0;
              if (id_r != ID_FMT || w != {16'd0, FMT_SIZE}) begin
                state_nxt = S_FAILED;
                pair_nxt.a.valid = 1'b1;
                pair_nxt.a.res = mk(KIND_ERROR, '0, ERR_BAD_FMT, 1'b0, 1'b0);
              end else begin
                fbad_nxt = 1'b0;
                state_nxt = S_FMT_BODY;
              end
            end
          end
          S_FMT_BODY: begin
            if (pos_r == 5'd1 && half != 16'd1) begin
              fbad_nxt = 1'b1;
            end
            if (pos_r == 5'd3 && half != {12'd0, exp_chan}) begin
              fbad_nxt = 1'b1;
            end
            if (pos_r == 5'd7 && w != {14'd0, exp_rate}) begin
              fbad_nxt = 1'b1;
            end
            if (pos_r == 5'd15) begin
              if (half != FMT_BITS || fbad_r) begin
                state_nxt = S_FAILED;
                pair_nxt.a.valid = 1'b1;
                pair_nxt.a.res = mk(KIND_ERROR, '0, ERR_UNSUP, 1'b0, 1'b0);
              end else begin
                state_nxt = S_CHUNK_HDR;
                pos_nxt = '0;
              end
            end else begin
              pos_nxt = pos_r + 5'd1;
            end
          end
          S_CHUNK_HDR: begin
            if (pos_r == 5'd3) begin
              id_nxt = w;
            end
            if (pos_r < 5'd7) begin
              pos_nxt = pos_r + 5'd1;
            end else begin
              pos_nxt = '0;
              if (w == '0) begin
                state_nxt = S_FAILED;
                pair_nxt.a.valid = 1'b1;
                pair_nxt.a.res = mk(KIND_ERROR, '0, ERR_ZERO, 1'b0, 1'b0);
              end else begin
                left_nxt = w;
                pad_nxt = w[0];
                if (id_r == ID_DATA) begin
                  samp_nxt = w[31:1];
                  chtg_nxt = 1'b0;
                  state_nxt = S_DATA;
                  pair_nxt.a.valid = 1'b1;
                  pair_nxt.a.res = mk(KIND_HEADER, {1'b0, w[31:1]}, 3'd0, 1'b0, 1'b0);
                end else if (id_r == ID_LIST && w >= 32'd4) begin
                  left_nxt = w - 32'd4;
                  state_nxt = S_LIST_TYPE;
                end else if (info_r && (id_r == ID_IART || id_r == ID_INAM)) begin
                  ttgt_nxt = (id_r == ID_INAM);
                  tcnt_nxt = '0;
                  tstop_nxt = 1'b0;
                  state_nxt = S_TEXT;
                end else begin
                  state_nxt = S_SKIP;
                end
              end
            end
          end
          S_LIST_TYPE: begin
            if (pos_r < 5'd3) begin
              pos_nxt = pos_r + 5'd1;
            end else begin
              pos_nxt = '0;
              if (w == ID_INFO) begin
                info_nxt = 1'b1;
                state_nxt = S_CHUNK_HDR;
              end else if (left_r == '0 && !pad_r) begin
                state_nxt = S_CHUNK_HDR;
              end else begin
                state_nxt = S_SKIP;
              end
            end
          end
          S_SKIP: begin
            if (left_r != '0) begin
              left_nxt = left_dec;
              if (left_dec == '0 && !pad_r) begin
                state_nxt = S_CHUNK_HDR;
                pos_nxt = '0;
              end
            end else begin
              pad_nxt = 1'b0;
              state_nxt = S_CHUNK_HDR;
              pos_nxt = '0;
            end
          end
          S_TEXT: begin
            left_nxt = left_dec;
            if (!tstop_r) begin
              if (data_byte == 8'd0) begin
                tstop_nxt = 1'b1;
                pair_nxt.a.valid = 1'b1;
                pair_nxt.a.res = mk(KIND_TEXTEND, {31'd0, ttgt_r}, 3'd0, 1'b0, 1'b0);
              end else begin
                pair_nxt.a.valid = 1'b1;
                pair_nxt.a.res = mk(ttgt_r ? KIND_TITLE : KIND_ARTIST, {24'd0, data_byte},
                                    3'd0, 1'b0, 1'b0);
                tcnt_nxt = tcnt_inc;
                if (tcnt_inc >= TEXT_LIM || left_dec == '0) begin
                  tstop_nxt = 1'b1;
                  pair_nxt.b.valid = 1'b1;
                  pair_nxt.b.res = mk(KIND_TEXTEND, {31'd0, ttgt_r}, 3'd0, 1'b0, 1'b0);
                end
              end
            end
            if (left_dec == '0) begin
              if (!tstop_r && !pair_nxt.a.valid) begin
                pair_nxt.a.valid = 1'b1;
                pair_nxt.a.res = mk(KIND_TEXTEND, {31'd0, ttgt_r}, 3'd0, 1'b0, 1'b0);
              end
              tstop_nxt = 1'b1;
              if (!pad_r) begin
                state_nxt = S_CHUNK_HDR;
                pos_nxt = '0;
              end else begin
                state_nxt = S_SKIP;
              end
            end
          end
          S_DATA: begin
            left_nxt = left_dec;
            if (!pos_r[0]) begin
              low_nxt = data_byte;
              pos_nxt = 5'd1;
            end else begin
              pos_nxt = '0;
              samp_nxt = samp_dec;
              pair_nxt.a.valid = 1'b1;
              pair_nxt.a.res = mk(KIND_PCM, {16'd0, data_byte, low_r}, 3'd0, chtg_r,
                                  samp_dec == '0);
              chtg_nxt = ~chtg_r;
            end
            if (left_dec == '0) begin
              state_nxt = S_DONE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RIFF_ID;
      pos_r <= '0;
      word_r <= '0;
      id_r <= '0;
      left_r <= '0;
      pad_r <= 1'b0;
      tcnt_r <= '0;
      ttgt_r <= 1'b0;
      tstop_r <= 1'b0;
      samp_r <= '0;
      low_r <= '0;
      chtg_r <= 1'b0;
      fbad_r <= 1'b0;
      info_r <= 1'b0;
      pair <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r <= pos_nxt;
      word_r <= word_nxt;
      id_r <= id_nxt;
      left_r <= left_nxt;
      pad_r <= pad_nxt;
      tcnt_r <= tcnt_nxt;
      ttgt_r <= ttgt_nxt;
      tstop_r <= tstop_nxt;
      samp_r <= samp_nxt;
      low_r <= low_nxt;
      chtg_r <= chtg_nxt;
      fbad_r <= fbad_nxt;
      info_r <= info_nxt;
      pair <= pair_nxt;
    end
  end

endmodule

// ===== hdl/wrhp_back.sv =====
// ----------------------------------------------------------------------------
// wrhp_back
// Result queue: takes up to two results per cycle from the front end and
// hands them out one at a time.
// ----------------------------------------------------------------------------
module wrhp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  wrhp_pkg::pair_t   pair,
  output logic              almost_full,
  output logic              empty,
  input  logic              pop,
  output wrhp_pkg::result_t head
);
  import wrhp_pkg::*;

  localparam int DEPTH = 8;

  result_t    mem_r [DEPTH];
  logic [2:0] wp_r, rp_r;
  logic [3:0] cnt_r, cnt_nxt;
  logic       do_pop;
  logic [1:0] n_in;

  assign empty = (cnt_r == 4'd0);
  assign head = mem_r[rp_r];
  assign do_pop = pop && !empty;
  assign n_in = {1'b0, pair.a.valid} + {1'b0, pair.b.valid};
  assign cnt_nxt = cnt_r + {2'd0, n_in} - {3'd0, do_pop};
  // Two entries in flight in the front end plus one new item need room.
  assign almost_full = (cnt_r > 4'd4);

  always_ff @(posedge clk) begin
    if (pair.a.valid) begin
      mem_r[wp_r] <= pair.a.res;
    end
    if (pair.b.valid) begin
      mem_r[pair.a.valid ? wp_r + 3'd1 : wp_r] <= pair.b.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_r + 3'(n_in);
      rp_r <= rp_r + 3'(do_pop);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/wav_riff_header_parser.sv =====
// ----------------------------------------------------------------------------
// wav_riff_header_parser
// Parses a WAV file byte stream: header checks, INFO text, PCM samples.
//
//   channel | ports                                  | handshake
//   input   | in_func, in_data_byte                  | in_push / in_full
//   result  | out_kind, out_value, out_error_code,   | out_pop / out_empty
//           | out_channel, out_last                  |
//   config  | cfg_index, cfg_data                    | cfg_valid / cfg_ready
//
// One byte is taken per cycle when in_full is low. Its results pass
// through the front-end register into the eight-entry queue, clearing
// out_empty; in_full rises when fewer than four places are sure to be free.
// Reset is synchronous and restores the register defaults.
// ----------------------------------------------------------------------------
module wav_riff_header_parser #(
  parameter int MAX_TEXT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic        in_func,
  input  logic [7:0]  in_data_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_kind,
  output logic [31:0] out_value,
  output logic [2:0]  out_error_code,
  output logic        out_channel,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [17:0] cfg_data
);
  import wrhp_pkg::*;

  logic [17:0] rate_r;
  logic [3:0]  chan_r;
  pair_t       pair;
  result_t     head;
  logic        afull;
  logic        step;

  assign cfg_ready = 1'b1;
  assign in_full = afull;
  assign step = in_push && !afull;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
      chan_r <= CHAN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RATE: rate_r <= cfg_data;
        CFG_CHAN: chan_r <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  wrhp_front #(.MAX_TEXT(MAX_TEXT)) u_front (
    .clk(clk), .rst_n(rst_n), .step(step), .func(in_func),
    .data_byte(in_data_byte), .exp_rate(rate_r), .exp_chan(chan_r), .pair(pair)
  );

  wrhp_back u_back (
    .clk(clk), .rst_n(rst_n), .pair(pair), .almost_full(afull),
    .empty(out_empty), .pop(out_pop), .head(head)
  );

  assign out_kind = head.kind;
  assign out_value = head.value;
  assign out_error_code = head.error_code;
  assign out_channel = head.channel;
  assign out_last = head.last;

endmodule
